[design/point_segment_distance_macros.svh]
// Assertion macros shared by the point_segment_distance design files.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef POINT_SEGMENT_DISTANCE_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_MACROS_SVH

// Same-cycle implication under the synchronous reset.
`define PSD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under the synchronous reset.
`define PSD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/psd_pkg.sv]
// Shared constants and types for the point-to-segment distance pipeline.
// No dependencies; imported by every module of the block.
package psd_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_BEGIN_X = 2'd0;
  localparam logic [1:0] REG_BEGIN_Y = 2'd1;
  localparam logic [1:0] REG_END_X   = 2'd2;
  localparam logic [1:0] REG_END_Y   = 2'd3;

  localparam logic [1:0] KIND_FOOT  = 2'd0;
  localparam logic [1:0] KIND_LEFT  = 2'd1;
  localparam logic [1:0] KIND_RIGHT = 2'd2;
  localparam logic [1:0] KIND_DEGEN = 2'd3;

  typedef struct packed {
    logic degen;
    logic dx_neg;
    logic dy_neg;
  } seg_flags_t;

endpackage

[design/psd_cfg.sv]
// Segment endpoint registers behind the APB port, plus values derived from them.
// Depends on psd_pkg.
module psd_cfg
  import psd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [APB_ADDR_W-1:0]          paddr,
  input  logic [APB_DATA_W-1:0]          pwdata,
  output logic [APB_DATA_W-1:0]          prdata,
  output logic signed [COORD_BITS-1:0]   bx,
  output logic signed [COORD_BITS-1:0]   by,
  output logic signed [COORD_BITS-1:0]   ex,
  output logic signed [COORD_BITS-1:0]   ey,
  output logic signed [COORD_BITS-1:0]   lx,
  output logic signed [COORD_BITS-1:0]   ly,
  output logic signed [COORD_BITS-1:0]   rx,
  output logic signed [COORD_BITS-1:0]   ry,
  output logic signed [COORD_BITS:0]     dx,
  output logic signed [COORD_BITS:0]     dy,
  output logic [COORD_BITS-1:0]          adx,
  output logic [COORD_BITS-1:0]          ady,
  output logic [2*COORD_BITS+1:0]        den,
  output seg_flags_t                     flags
);

  localparam int C = COORD_BITS;

  logic signed [C-1:0] bx_r, by_r, ex_r, ey_r;
  logic signed [C-1:0] lx_r, ly_r, rx_r, ry_r;
  logic signed [C:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  logic [C-1:0]        adx_r, ady_r;
  logic [2*C+1:0]      dsqx_r, dsqy_r, den_r;
  seg_flags_t          flags_r;
  logic                wr;
  logic [1:0]          idx;
  logic signed [C-1:0] rd_sel;
  logic                left_is_end;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bx_r <= '0;
      by_r <= '0;
      ex_r <= '0;
      ey_r <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_BEGIN_X: bx_r <= pwdata[C-1:0];
        REG_BEGIN_Y: by_r <= pwdata[C-1:0];
        REG_END_X:   ex_r <= pwdata[C-1:0];
        REG_END_Y:   ey_r <= pwdata[C-1:0];
        default:     bx_r <= bx_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BEGIN_X: rd_sel = bx_r;
      REG_BEGIN_Y: rd_sel = by_r;
      REG_END_X:   rd_sel = ex_r;
      REG_END_Y:   rd_sel = ey_r;
      default:     rd_sel = bx_r;
    endcase
  end

  assign prdata = APB_DATA_W'(rd_sel);

  assign dx_nxt      = (C+1)'(ex_r) - (C+1)'(bx_r);
  assign dy_nxt      = (C+1)'(ey_r) - (C+1)'(by_r);
  assign left_is_end = bx_r > ex_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r    <= '0;
      dy_r    <= '0;
      adx_r   <= '0;
      ady_r   <= '0;
      dsqx_r  <= '0;
      dsqy_r  <= '0;
      den_r   <= '0;
      lx_r    <= '0;
      ly_r    <= '0;
      rx_r    <= '0;
      ry_r    <= '0;
      flags_r <= '{degen: 1'b1, dx_neg: 1'b0, dy_neg: 1'b0};
    end else begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      adx_r   <= dx_nxt[C] ? C'(-dx_nxt) : C'(dx_nxt);
      ady_r   <= dy_nxt[C] ? C'(-dy_nxt) : C'(dy_nxt);
      dsqx_r  <= dx_r * dx_r;
      dsqy_r  <= dy_r * dy_r;
      den_r   <= dsqx_r + dsqy_r;
      lx_r    <= left_is_end ? ex_r : bx_r;
      ly_r    <= left_is_end ? ey_r : by_r;
      rx_r    <= left_is_end ? bx_r : ex_r;
      ry_r    <= left_is_end ? by_r : ey_r;
      flags_r <= '{degen:  (bx_r == ex_r) && (by_r == ey_r),
                   dx_neg: dx_nxt[C],
                   dy_neg: dy_nxt[C]};
    end
  end

  assign bx    = bx_r;
  assign by    = by_r;
  assign ex    = ex_r;
  assign ey    = ey_r;
  assign lx    = lx_r;
  assign ly    = ly_r;
  assign rx    = rx_r;
  assign ry    = ry_r;
  assign dx    = dx_r;
  assign dy    = dy_r;
  assign adx   = adx_r;
  assign ady   = ady_r;
  assign den   = den_r;
  assign flags = flags_r;

endmodule

[design/psd_front.sv]
// Front pipeline: projection numerator, interior test, endpoint choice and
// the scaled dividends for the foot. Depends on psd_pkg.
module psd_front
  import psd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_in,
  input  logic signed [COORD_BITS-1:0]  px,
  input  logic signed [COORD_BITS-1:0]  py,
  input  logic signed [COORD_BITS-1:0]  bx,
  input  logic signed [COORD_BITS-1:0]  by,
  input  logic signed [COORD_BITS-1:0]  lx,
  input  logic signed [COORD_BITS-1:0]  ly,
  input  logic signed [COORD_BITS-1:0]  rx,
  input  logic signed [COORD_BITS-1:0]  ry,
  input  logic signed [COORD_BITS:0]    dx,
  input  logic signed [COORD_BITS:0]    dy,
  input  logic [COORD_BITS-1:0]         adx,
  input  logic [COORD_BITS-1:0]         ady,
  input  logic [2*COORD_BITS+1:0]       den,
  input  seg_flags_t                    flags,
  output logic                          v_out,
  output logic [3*COORD_BITS+3:0]       nx,
  output logic [3*COORD_BITS+3:0]       ny,
  output logic [4*COORD_BITS+1:0]       side
);

  localparam int C = COORD_BITS;

  logic [6:0] v_r;

  logic signed [C-1:0]   p1x_r, p1y_r, p2x_r, p2y_r, p3x_r, p3y_r, p4x_r, p4y_r;
  logic signed [C-1:0]   p5x_r, p5y_r, p6x_r, p6y_r, p7x_r, p7y_r;
  logic signed [C:0]     e2x_r, e2y_r, l2x_r, l2y_r, r2x_r, r2y_r;
  logic signed [2*C+1:0] n3x_r, n3y_r;
  logic [2*C+1:0]        ql3x_r, ql3y_r, qr3x_r, qr3y_r;
  logic signed [2*C+2:0] num4_r;
  logic [2*C+1:0]        dl4_r, dr4_r;
  logic [2*C+1:0]        nm5_r;
  logic [1:0]            kind5_r, kind6_r, kind7_r, kind5_nxt;
  logic signed [C-1:0]   ep5x_r, ep5y_r, ep6x_r, ep6y_r, ep7x_r, ep7y_r;
  logic signed [C-1:0]   ep5x_nxt, ep5y_nxt;
  logic [2*C:0]          pxl6_r, pxh6_r, pyl6_r, pyh6_r;
  logic [3*C+3:0]        nx7_r, ny7_r;
  logic [3*C+1:0]        mx, my;
  logic                  interior;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], v_in};
    end
  end

  assign interior = !num4_r[2*C+2] && (num4_r[2*C+1:0] <= den);

  always_comb begin
    kind5_nxt = KIND_RIGHT;
    ep5x_nxt  = rx;
    ep5y_nxt  = ry;
    if (flags.degen) begin
      kind5_nxt = KIND_DEGEN;
      ep5x_nxt  = bx;
      ep5y_nxt  = by;
    end else if (interior) begin
      kind5_nxt = KIND_FOOT;
      ep5x_nxt  = bx;
      ep5y_nxt  = by;
    end else if (dl4_r < dr4_r) begin
      kind5_nxt = KIND_LEFT;
      ep5x_nxt  = lx;
      ep5y_nxt  = ly;
    end
  end

  assign mx = (3*C+2)'({pxh6_r, {(C+1){1'b0}}}) + (3*C+2)'(pxl6_r);
  assign my = (3*C+2)'({pyh6_r, {(C+1){1'b0}}}) + (3*C+2)'(pyl6_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p1x_r   <= px;
      p1y_r   <= py;

      e2x_r   <= (C+1)'(p1x_r) - (C+1)'(bx);
      e2y_r   <= (C+1)'(p1y_r) - (C+1)'(by);
      l2x_r   <= (C+1)'(p1x_r) - (C+1)'(lx);
      l2y_r   <= (C+1)'(p1y_r) - (C+1)'(ly);
      r2x_r   <= (C+1)'(p1x_r) - (C+1)'(rx);
      r2y_r   <= (C+1)'(p1y_r) - (C+1)'(ry);
      p2x_r   <= p1x_r;
      p2y_r   <= p1y_r;

      n3x_r   <= e2x_r * dx;
      n3y_r   <= e2y_r * dy;
      ql3x_r  <= l2x_r * l2x_r;
      ql3y_r  <= l2y_r * l2y_r;
      qr3x_r  <= r2x_r * r2x_r;
      qr3y_r  <= r2y_r * r2y_r;
      p3x_r   <= p2x_r;
      p3y_r   <= p2y_r;

      num4_r  <= (2*C+3)'(n3x_r) + (2*C+3)'(n3y_r);
      dl4_r   <= ql3x_r + ql3y_r;
      dr4_r   <= qr3x_r + qr3y_r;
      p4x_r   <= p3x_r;
      p4y_r   <= p3y_r;

      nm5_r   <= num4_r[2*C+1:0];
      kind5_r <= kind5_nxt;
      ep5x_r  <= ep5x_nxt;
      ep5y_r  <= ep5y_nxt;
      p5x_r   <= p4x_r;
      p5y_r   <= p4y_r;

      pxl6_r  <= adx * nm5_r[C:0];
      pxh6_r  <= adx * nm5_r[2*C+1:C+1];
      pyl6_r  <= ady * nm5_r[C:0];
      pyh6_r  <= ady * nm5_r[2*C+1:C+1];
      kind6_r <= kind5_r;
      ep6x_r  <= ep5x_r;
      ep6y_r  <= ep5y_r;
      p6x_r   <= p5x_r;
      p6y_r   <= p5y_r;

      nx7_r   <= (3*C+4)'({mx, 1'b0}) + (3*C+4)'(den);
      ny7_r   <= (3*C+4)'({my, 1'b0}) + (3*C+4)'(den);
      kind7_r <= kind6_r;
      ep7x_r  <= ep6x_r;
      ep7y_r  <= ep6y_r;
      p7x_r   <= p6x_r;
      p7y_r   <= p6y_r;
    end
  end

  assign v_out = v_r[6];
  assign nx    = nx7_r;
  assign ny    = ny7_r;
  assign side  = {kind7_r, ep7x_r, ep7y_r, p7x_r, p7y_r};

endmodule

[design/psd_div.sv]
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing
// one divisor. Depends on psd_pkg.
module psd_div
  import psd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SIDE_W     = 4*COORD_BITS_DEF+2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     v_in,
  input  logic [3*COORD_BITS+3:0]  nx,
  input  logic [3*COORD_BITS+3:0]  ny,
  input  logic [2*COORD_BITS+1:0]  den,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     v_out,
  output logic [COORD_BITS-1:0]    qx,
  output logic [COORD_BITS-1:0]    qy,
  output logic [SIDE_W-1:0]        side_out
);

  localparam int C  = COORD_BITS;
  localparam int NW = 3*C+4;

  logic [C-1:0]     v_r;
  logic [NW-1:0]    remx_r [C];
  logic [NW-1:0]    remy_r [C];
  logic [NW-1:0]    remx_in [C];
  logic [NW-1:0]    remy_in [C];
  logic [NW-1:0]    remx_nxt [C];
  logic [NW-1:0]    remy_nxt [C];
  logic [NW-1:0]    dsh [C];
  logic [C-1:0]     qx_r [C];
  logic [C-1:0]     qy_r [C];
  logic [C-1:0]     qx_in [C];
  logic [C-1:0]     qy_in [C];
  logic [C-1:0]     qx_nxt [C];
  logic [C-1:0]     qy_nxt [C];
  logic [SIDE_W-1:0] side_r [C];
  logic [SIDE_W-1:0] side_ls [C];

  always_comb begin
    remx_in[0] = nx;
    remy_in[0] = ny;
    qx_in[0]   = '0;
    qy_in[0]   = '0;
    side_ls[0] = side_in;
    for (int k = 1; k < C; k++) begin
      remx_in[k] = remx_r[k-1];
      remy_in[k] = remy_r[k-1];
      qx_in[k]   = qx_r[k-1];
      qy_in[k]   = qy_r[k-1];
      side_ls[k] = side_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < C; k++) begin
      dsh[k] = NW'({den, 1'b0}) << (C-1-k);
      if (remx_in[k] >= dsh[k]) begin
        remx_nxt[k] = remx_in[k] - dsh[k];
        qx_nxt[k]   = qx_in[k] | (C'(1) << (C-1-k));
      end else begin
        remx_nxt[k] = remx_in[k];
        qx_nxt[k]   = qx_in[k];
      end
      if (remy_in[k] >= dsh[k]) begin
        remy_nxt[k] = remy_in[k] - dsh[k];
        qy_nxt[k]   = qy_in[k] | (C'(1) << (C-1-k));
      end else begin
        remy_nxt[k] = remy_in[k];
        qy_nxt[k]   = qy_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[C-2:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < C; k++) begin
        remx_r[k] <= remx_nxt[k];
        remy_r[k] <= remy_nxt[k];
        qx_r[k]   <= qx_nxt[k];
        qy_r[k]   <= qy_nxt[k];
        side_r[k] <= side_ls[k];
      end
    end
  end

  assign v_out    = v_r[C-1];
  assign qx       = qx_r[C-1];
  assign qy       = qy_r[C-1];
  assign side_out = side_r[C-1];

endmodule

[design/psd_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on psd_pkg.
module psd_sqrt
  import psd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SIDE_W     = 2*COORD_BITS_DEF+2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     v_in,
  input  logic [2*COORD_BITS+1:0]  sq,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     v_out,
  output logic [COORD_BITS:0]      root,
  output logic [SIDE_W-1:0]        side_out
);

  localparam int R   = COORD_BITS+1;
  localparam int SQW = 2*COORD_BITS+2;

  logic [R-1:0]      v_r;
  logic [SQW-1:0]    rem_r [R];
  logic [SQW-1:0]    rem_in [R];
  logic [SQW-1:0]    rem_nxt [R];
  logic [SQW-1:0]    cand [R];
  logic [R-1:0]      rt_r [R];
  logic [R-1:0]      rt_in [R];
  logic [R-1:0]      rt_nxt [R];
  logic [SIDE_W-1:0] side_r [R];
  logic [SIDE_W-1:0] side_ls [R];

  always_comb begin
    rem_in[0]  = sq;
    rt_in[0]   = '0;
    side_ls[0] = side_in;
    for (int k = 1; k < R; k++) begin
      rem_in[k]  = rem_r[k-1];
      rt_in[k]   = rt_r[k-1];
      side_ls[k] = side_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < R; k++) begin
      cand[k] = (SQW'(rt_in[k]) << (R-k)) | (SQW'(1) << (2*(R-1-k)));
      if (rem_in[k] >= cand[k]) begin
        rem_nxt[k] = rem_in[k] - cand[k];
        rt_nxt[k]  = rt_in[k] | (R'(1) << (R-1-k));
      end else begin
        rem_nxt[k] = rem_in[k];
        rt_nxt[k]  = rt_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[R-2:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < R; k++) begin
        rem_r[k]  <= rem_nxt[k];
        rt_r[k]   <= rt_nxt[k];
        side_r[k] <= side_ls[k];
      end
    end
  end

  assign v_out    = v_r[R-1];
  assign root     = rt_r[R-1];
  assign side_out = side_r[R-1];

endmodule

[design/point_segment_distance.sv]
// Throughput: one beat per cycle when the output is not stalled.
// The divider and root pipelines set the depth.
// A result waiting at the output stalls the whole pipeline until it is taken.
// Reset is synchronous, active low: it clears all valid bits and the segment
// registers to zero; no clearing pass is needed.
`include "point_segment_distance_macros.svh"

module point_segment_distance
  import psd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]        prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_closest_x,
  output logic signed [COORD_BITS-1:0] out_closest_y,
  output logic [COORD_BITS:0]          out_distance,
  output logic [1:0]                   out_nearest_kind
);

  localparam int C   = COORD_BITS;
  localparam int FSW = 4*C+2;
  localparam int RSW = 2*C+2;

  logic signed [C-1:0] bx, by, ex, ey, lx, ly, rx, ry;
  logic signed [C:0]   dx, dy;
  logic [C-1:0]        adx, ady;
  logic [2*C+1:0]      den;
  seg_flags_t          flags;

  logic                en;
  logic                v_f, v_d, v_sq;
  logic [3*C+3:0]      nx, ny;
  logic [FSW-1:0]      side_f, side_d;
  logic [C-1:0]        qx, qy;
  logic [1:0]          kind_d;
  logic signed [C-1:0] epx_d, epy_d, px_d, py_d;
  logic signed [C:0]   offx, offy;

  logic [3:0]            vb_r;
  logic [1:0]            kind1_r, kind2_r, kind3_r, kind4_r;
  logic signed [C-1:0]   cx1_r, cy1_r, cx2_r, cy2_r, cx3_r, cy3_r, cx4_r, cy4_r;
  logic signed [C-1:0]   px1_r, py1_r;
  logic signed [C:0]     ddx2_r, ddy2_r;
  logic [2*C+1:0]        sq3x_r, sq3y_r, s4_r;
  logic [C:0]            root;
  logic [RSW-1:0]        side_sq;

  logic                  out_valid_r;
  logic signed [C-1:0]   out_cx_r, out_cy_r;
  logic [C:0]            out_dist_r;
  logic [1:0]            out_kind_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign pready   = 1'b1;

  psd_cfg #(.COORD_BITS(C)) u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .bx, .by, .ex, .ey, .lx, .ly, .rx, .ry,
    .dx, .dy, .adx, .ady, .den, .flags
  );

  psd_front #(.COORD_BITS(C)) u_front (
    .clk, .rst_n, .en,
    .v_in (in_valid && in_ready),
    .px   (in_point_x),
    .py   (in_point_y),
    .bx, .by, .lx, .ly, .rx, .ry, .dx, .dy, .adx, .ady, .den, .flags,
    .v_out(v_f),
    .nx, .ny,
    .side (side_f)
  );

  psd_div #(.COORD_BITS(C), .SIDE_W(FSW)) u_div (
    .clk, .rst_n, .en,
    .v_in    (v_f),
    .nx, .ny, .den,
    .side_in (side_f),
    .v_out   (v_d),
    .qx, .qy,
    .side_out(side_d)
  );

  assign kind_d = side_d[4*C+1:4*C];
  assign epx_d  = side_d[4*C-1:3*C];
  assign epy_d  = side_d[3*C-1:2*C];
  assign px_d   = side_d[2*C-1:C];
  assign py_d   = side_d[C-1:0];

  assign offx = flags.dx_neg ? -(C+1)'(qx) : (C+1)'(qx);
  assign offy = flags.dy_neg ? -(C+1)'(qy) : (C+1)'(qy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else if (en) begin
      vb_r <= {vb_r[2:0], v_d};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1_r <= kind_d;
      cx1_r   <= (kind_d == KIND_FOOT) ? C'((C+1)'(bx) + offx) : epx_d;
      cy1_r   <= (kind_d == KIND_FOOT) ? C'((C+1)'(by) + offy) : epy_d;
      px1_r   <= px_d;
      py1_r   <= py_d;

      ddx2_r  <= (C+1)'(px1_r) - (C+1)'(cx1_r);
      ddy2_r  <= (C+1)'(py1_r) - (C+1)'(cy1_r);
      kind2_r <= kind1_r;
      cx2_r   <= cx1_r;
      cy2_r   <= cy1_r;

      sq3x_r  <= ddx2_r * ddx2_r;
      sq3y_r  <= ddy2_r * ddy2_r;
      kind3_r <= kind2_r;
      cx3_r   <= cx2_r;
      cy3_r   <= cy2_r;

      s4_r    <= sq3x_r + sq3y_r;
      kind4_r <= kind3_r;
      cx4_r   <= cx3_r;
      cy4_r   <= cy3_r;
    end
  end

  psd_sqrt #(.COORD_BITS(C), .SIDE_W(RSW)) u_sqrt (
    .clk, .rst_n, .en,
    .v_in    (vb_r[3]),
    .sq      (s4_r),
    .side_in ({kind4_r, cx4_r, cy4_r}),
    .v_out   (v_sq),
    .root,
    .side_out(side_sq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind_r <= side_sq[2*C+1:2*C];
      out_cx_r   <= side_sq[2*C-1:C];
      out_cy_r   <= side_sq[C-1:0];
      out_dist_r <= root;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_closest_x    = out_cx_r;
  assign out_closest_y    = out_cy_r;
  assign out_distance     = out_dist_r;
  assign out_nearest_kind = out_kind_r;

  `PSD_ASSERT_NOW(a_degen_is_begin, clk, rst_n,
    out_valid_r && (out_kind_r == KIND_DEGEN),
    (out_cx_r == bx) && (out_cy_r == by), "degenerate result is not the begin point")
  `PSD_ASSERT_NOW(a_left_is_left, clk, rst_n,
    out_valid_r && (out_kind_r == KIND_LEFT),
    (out_cx_r == lx) && (out_cy_r == ly), "left result is not the left endpoint")
  `PSD_ASSERT_NOW(a_foot_in_box, clk, rst_n,
    out_valid_r && (out_kind_r == KIND_FOOT),
    ((out_cx_r >= bx) || (out_cx_r >= ex)) && ((out_cx_r <= bx) || (out_cx_r <= ex)) &&
    ((out_cy_r >= by) || (out_cy_r >= ey)) && ((out_cy_r <= by) || (out_cy_r <= ey)),
    "foot lies outside the segment box")
  `PSD_ASSERT_NEXT(a_stall_freezes, clk, rst_n,
    out_valid_r && !out_ready,
    $stable(vb_r) && $stable(v_sq) && $stable(v_d), "pipeline moved during a stall")

endmodule

[tb/point_segment_distance_checker.sv]
// Checker for point_segment_distance: snoops register writes and both channels,
// predicts each result from the segment registers and compares it field by field.
// Depends on psd_pkg for the register indexes and the result kind codes.
module point_segment_distance_checker
  import psd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [15:0]       in_point_x,
  input  logic signed [15:0]       in_point_y,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [15:0]       out_closest_x,
  input  logic signed [15:0]       out_closest_y,
  input  logic [16:0]              out_distance,
  input  logic [1:0]               out_nearest_kind,
  output int                       errors,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [16:0]        root;
    logic [1:0]         kind;
  } nearest_t;

  logic signed [15:0] seg_bx, seg_by, seg_ex, seg_ey;
  nearest_t nearest_q[$];

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((2 * (-num) + den) / (2 * den));
  endfunction

  function automatic nearest_t nearest_point(longint px, longint py);
    nearest_t r;
    longint bx, by, ex, ey, dx, dy, den, num, lx, ly, rx, ry, cx, cy, ddx, ddy;
    logic [1:0] kind;
    bx = seg_bx; by = seg_by; ex = seg_ex; ey = seg_ey;
    dx = ex - bx;
    dy = ey - by;
    if (dx == 0 && dy == 0) begin
      cx = bx; cy = by; kind = KIND_DEGEN;
    end else begin
      den = dx * dx + dy * dy;
      num = (px - bx) * dx + (py - by) * dy;
      if (num >= 0 && num <= den) begin
        cx = bx + round_div(dx * num, den);
        cy = by + round_div(dy * num, den);
        kind = KIND_FOOT;
      end else begin
        if (bx > ex) begin
          lx = ex; ly = ey; rx = bx; ry = by;
        end else begin
          lx = bx; ly = by; rx = ex; ry = ey;
        end
        if ((px-lx)*(px-lx) + (py-ly)*(py-ly) < (px-rx)*(px-rx) + (py-ry)*(py-ry)) begin
          cx = lx; cy = ly; kind = KIND_LEFT;
        end else begin
          cx = rx; cy = ry; kind = KIND_RIGHT;
        end
      end
    end
    ddx = px - cx;
    ddy = py - cy;
    r.cx = cx[15:0];
    r.cy = cy[15:0];
    r.root = 17'(floor_root(ddx * ddx + ddy * ddy));
    r.kind = kind;
    return r;
  endfunction

  always @(posedge clk) begin
    nearest_t e;
    if (!rst_n) begin
      seg_bx <= '0; seg_by <= '0; seg_ex <= '0; seg_ey <= '0;
      nearest_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BEGIN_X: seg_bx <= pwdata[15:0];
          REG_BEGIN_Y: seg_by <= pwdata[15:0];
          REG_END_X:   seg_ex <= pwdata[15:0];
          REG_END_Y:   seg_ey <= pwdata[15:0];
        endcase
      end
      if (in_valid && in_ready) nearest_q.push_back(nearest_point(in_point_x, in_point_y));
      if (out_valid && out_ready) begin
        if (nearest_q.size() == 0) begin
          $display("%t: result beat with nothing expected: %0d %0d %0d %0d", $time,
                   out_closest_x, out_closest_y, out_distance, out_nearest_kind);
          errors <= errors + 1;
        end else begin
          e = nearest_q.pop_front();
          if (e.cx !== out_closest_x || e.cy !== out_closest_y ||
              e.root !== out_distance || e.kind !== out_nearest_kind) begin
            $display("%t: mismatch expected x=%0d y=%0d dist=%0d kind=%0d", $time,
                     e.cx, e.cy, e.root, e.kind);
            $display("%t:            actual x=%0d y=%0d dist=%0d kind=%0d", $time,
                     out_closest_x, out_closest_y, out_distance, out_nearest_kind);
            errors <= errors + 1;
          end
        end
      end
      pending <= nearest_q.size();
    end
  end
endmodule

[tb/point_segment_distance_test.sv]
// Top of the point_segment_distance testbench: clock, reset, register writes,
// point stimulus with idling phases, and the verdict. Uses the checker module and psd_pkg.
module point_segment_distance_test;
  import psd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic clk = 0, rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [15:0] in_point_x = '0, in_point_y = '0, out_closest_x, out_closest_y;
  logic [16:0] out_distance;
  logic [1:0] out_nearest_kind;
  int errors, pending;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_reqs = 0, hold_seen = 0, hold_cnt = 0, quiet = 0;
  int n_points = 0;
  logic signed [15:0] sbx, sby, sex, sey;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  point_segment_distance i_dut (.*);

  point_segment_distance_checker i_check (.*);

  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_cnt <= 300;
      out_ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("%t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("point_segment_distance_test: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic signed [15:0] v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= {{16{v[15]}}, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_segment(logic signed [15:0] bx, by, ex, ey);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    write_reg(REG_BEGIN_X, bx);
    write_reg(REG_BEGIN_Y, by);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
    sbx = bx; sby = by; sex = ex; sey = ey;
  endtask

  task automatic send_point(logic signed [15:0] x, y);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_point_x <= x;
    in_point_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_points++;
  endtask

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  task automatic random_points(int count);
    longint t, ox, oy;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        send_point(16'($urandom), 16'($urandom));
      end else begin
        t = $signed($urandom_range(1400)) - 200;
        ox = $signed($urandom_range(512)) - 256;
        oy = $signed($urandom_range(512)) - 256;
        send_point(clamp16(sbx + (longint'(sex) - sbx) * t / 1000 + ox),
                   clamp16(sby + (longint'(sey) - sby) * t / 1000 + oy));
      end
    end
  endtask

  initial begin
    logic signed [15:0] seg[6][4];
    logic signed [15:0] corner[3] = '{-16'sd32768, 16'sd0, 16'sd32767};
    seg = '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767},
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
            '{16'sd32767, 16'sd0, -16'sd32768, 16'sd0},
            '{16'sd80, -16'sd1600, 16'sd80, 16'sd1600},
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0}};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    for (int p = 0; p < 6; p++) begin
      if (p >= 4) seg[p] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      set_segment(seg[p][0], seg[p][1], seg[p][2], seg[p][3]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 67; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 67; end
        default: begin send_idle_pct = 22; recv_idle_pct = 22; end
      endcase
      if (p < 3) begin
        foreach (corner[i]) foreach (corner[j]) send_point(corner[i], corner[j]);
        send_point(16'sd1, -16'sd1);
        send_point(-16'sd1, 16'sd1);
        send_point(seg[p][0], seg[p][1]);
        send_point(seg[p][2], seg[p][3]);
      end
      if (p == 1) hold_reqs++;
      random_points(85);
      if (p == 2) begin
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      random_points(85);
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d points over six segments: full-range diagonal, degenerate,", n_points);
    $display("reversed horizontal, vertical and random, under four idling mixes.");
    if (errors == 0 && pending == 0) begin
      $display("point_segment_distance_test: PASS");
    end else begin
      $display("point_segment_distance_test: FAIL");
    end
    $finish;
  end
endmodule
